@@ sv/convolutional_byte_deinterleaver_macros.svh @@
// Assertion helpers for the checker file.
`ifndef CONVOLUTIONAL_BYTE_DEINTERLEAVER_MACROS_SVH
`define CONVOLUTIONAL_BYTE_DEINTERLEAVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CBDI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deinterleaver check failed");

// Next-cycle implication, disabled while reset is high.
`define CBDI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deinterleaver check failed");

// Next-cycle implication that also holds across reset.
`define CBDI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("deinterleaver check failed");

`endif

@@ sv/cbdi_pkg.sv @@
`default_nettype none

package cbdi_pkg;

   // One stream byte.
   typedef logic [7:0] byte_type;

endpackage

`default_nettype wire

@@ sv/cbdi_store.sv @@
`default_nettype none

module cbdi_store #(
   parameter int DEPTH = 1122,
   parameter int AW    = 11
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [AW-1:0]      addr,
   input  wire cbdi_pkg::byte_type wdata,
   output cbdi_pkg::byte_type      rdata
);

   cbdi_pkg::byte_type mem [DEPTH];
   cbdi_pkg::byte_type rdata_ff;

   // Read the old byte and write the new one at the same address (read-first).
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff  <= mem[addr];
         mem[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/convolutional_byte_deinterleaver.sv @@
// Convolutional byte deinterleaver, BRANCHES branches with delays that step by
// DEPTH_UNIT bytes. Branch j delays its bytes by DEPTH_UNIT*(BRANCHES-1-j) bytes;
// the last branch passes its byte straight through.
// Request channel: req_valid / req_stall / req_data_in, one byte per request.
// Response channel: rsp_valid / rsp_stall / rsp_data_out, one byte per request,
// in request order.
// Pipeline: an accepted request is registered in stage 1, then in the response
// register, which drives rsp_valid; a response stall can hold it in between.
// Throughput: one request per cycle unless a response stall holds the pipeline;
// each request not on the last branch reads, then writes, the same address of the single-port delay store.
// Reset: the branch selector returns to branch 0, every branch pointer returns
// to the start of its region and the per-branch fill flags clear. The store
// itself is not swept; a branch whose pointer has not yet wrapped answers with
// zero, so requests are taken right from the first cycle after reset.
// Stall: a stalled response holds; the stage behind it still takes one more
// request if it is empty, then req_stall rises until the response is taken.
`default_nettype none

module convolutional_byte_deinterleaver #(
   parameter int BRANCHES   = 12,
   parameter int DEPTH_UNIT = 17
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire cbdi_pkg::byte_type req_data_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output cbdi_pkg::byte_type      rsp_data_out
);

   localparam int STORE_SIZE = DEPTH_UNIT * BRANCHES * (BRANCHES - 1) / 2;
   localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int IW         = $clog2(BRANCHES);
   localparam int LANES      = BRANCHES - 1;

   typedef enum logic [1:0] {
      SRC_STORE,
      SRC_ZERO,
      SRC_PASS
   } src_type;

   // First store entry of branch j.
   function automatic int base_of(input int j);
      int acc;
      acc = 0;
      for (int b = 0; b < BRANCHES; b++) begin
         if (b < j) begin
            acc = acc + DEPTH_UNIT * (BRANCHES - 1 - b);
         end
      end
      return acc;
   endfunction

   logic [IW-1:0]      index_ff;
   logic [IW-1:0]      index_in;
   logic [AW-1:0]      addr_ff   [LANES];
   logic [LANES-1:0]   filled_ff;
   logic               accept;
   logic               last_branch;
   logic [AW-1:0]      cur_addr;
   logic               cur_filled;
   logic               s1_valid_ff;
   src_type            s1_src_ff;
   cbdi_pkg::byte_type s1_byte_ff;
   logic               s1_move;
   logic               rsp_valid_ff;
   cbdi_pkg::byte_type rsp_data_ff;
   cbdi_pkg::byte_type store_rdata;

   // Pipeline flow: stage 1 moves when the response register is free or taken.
   assign s1_move   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign last_branch = (index_ff == IW'(BRANCHES - 1));
   assign index_in    = last_branch ? '0 : index_ff + IW'(1);

   // Select the current branch's pointer and fill flag.
   always_comb begin
      cur_addr   = '0;
      cur_filled = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         if (index_ff == IW'(k)) begin
            cur_addr   = addr_ff[k];
            cur_filled = filled_ff[k];
         end
      end
   end

   // Advance the branch selector.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
      end else if (accept) begin
         index_ff <= index_in;
      end
   end

   // Per-branch pointers: wrap inside the branch region, mark filled on wrap.
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      localparam logic [AW-1:0] BASE = AW'(base_of(j));
      localparam logic [AW-1:0] LAST = AW'(base_of(j) + DEPTH_UNIT * (BRANCHES - 1 - j) - 1);

      always_ff @(posedge clock) begin
         if (reset) begin
            addr_ff[j]   <= BASE;
            filled_ff[j] <= 1'b0;
         end else if (accept && index_ff == IW'(j)) begin
            if (addr_ff[j] == LAST) begin
               addr_ff[j]   <= BASE;
               filled_ff[j] <= 1'b1;
            end else begin
               addr_ff[j] <= addr_ff[j] + AW'(1);
            end
         end
      end
   end

   // Branch regions are disjoint and an entry recurs only after a full
   // branch cycle, so read-first access needs no forwarding.
   cbdi_store #(
      .DEPTH (STORE_SIZE),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .en    (accept && !last_branch),
      .addr  (cur_addr),
      .wdata (req_data_in),
      .rdata (store_rdata)
   );

   // Stage 1: remember where the response byte comes from.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_byte_ff <= req_data_in;
         if (last_branch) begin
            s1_src_ff <= SRC_PASS;
         end else if (cur_filled) begin
            s1_src_ff <= SRC_STORE;
         end else begin
            s1_src_ff <= SRC_ZERO;
         end
      end
   end

   // Response register: load when stage 1 moves, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_move && s1_valid_ff) begin
         case (s1_src_ff)
            SRC_STORE: rsp_data_ff <= store_rdata;
            SRC_PASS:  rsp_data_ff <= s1_byte_ff;
            default:   rsp_data_ff <= '0;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/cbdi_checker.sv @@
`default_nettype none

`include "convolutional_byte_deinterleaver_macros.svh"

module cbdi_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire cbdi_pkg::byte_type rsp_data_out
);

   // Reset empties the response register.
   `CBDI_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // Request side stalls only when a held response blocks the pipeline.
   `CBDI_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A request, then a free response side, passes stage 1 to rsp_valid.
   `CBDI_ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall, rsp_valid)

   // A stalled response holds its byte.
   `CBDI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data_out))

endmodule

bind convolutional_byte_deinterleaver cbdi_checker u_cbdi_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_data_out (rsp_data_out)
);

`default_nettype wire
